[rtl/lspv_pkg.sv]
// Shared types and constants for the looping sample playback voice.
// Holds field widths, the action and register codes, and tdata bit offsets.
// No dependencies. Compile this file first.
package lspv_pkg;

    localparam int C_MAX_FRAMES      = 4096;
    localparam int C_ADDR_W          = 12;
    localparam int C_POS_W           = 13;
    localparam int C_SAMP_W          = 16;
    localparam int C_GAIN_W          = 16;
    localparam int C_MIX_W           = 24;
    localparam int C_GAIN_FRAC_BITS  = 12;
    localparam int C_CFG_IDX_W       = 3;
    localparam int C_CFG_DATA_W      = 16;

    // slave tdata layout, lowest bit first
    localparam int C_FC_LSB   = 0;
    localparam int C_ADDR_LSB = C_FC_LSB + C_POS_W;
    localparam int C_SL_LSB   = C_ADDR_LSB + C_ADDR_W;
    localparam int C_SR_LSB   = C_SL_LSB + C_SAMP_W;
    localparam int C_ML_LSB   = C_SR_LSB + C_SAMP_W;
    localparam int C_MR_LSB   = C_ML_LSB + C_MIX_W;
    localparam int C_IN_USED  = C_MR_LSB + C_MIX_W;
    localparam int C_IN_DATA_W = ((C_IN_USED + 7) / 8) * 8;

    // master tdata layout, lowest bit first
    localparam int C_OUT_USED   = 2 * C_MIX_W + 1;
    localparam int C_OUT_DATA_W = ((C_OUT_USED + 7) / 8) * 8;

    localparam logic [C_POS_W-1:0]         C_MAX_LEN    = C_POS_W'(C_MAX_FRAMES);
    localparam logic signed [C_GAIN_W-1:0] C_GAIN_UNITY = C_GAIN_W'(4096);

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_TRIGGER = 2'd1,
        ACT_STOP    = 2'd2,
        ACT_LOAD    = 2'd3
    } t_action;

    typedef enum logic [C_CFG_IDX_W-1:0] {
        REG_GAIN_LEFT   = 3'd0,
        REG_GAIN_RIGHT  = 3'd1,
        REG_LOOP_ENABLE = 3'd2,
        REG_LOOP_BEGIN  = 3'd3,
        REG_LOOP_FINISH = 3'd4
    } t_cfg_reg;

endpackage

[rtl/looping_sample_playback_voice_core.sv]
// Top level of the looping stereo sample playback voice.
// Frame store memory, voice position control and the three-stage mix pipeline.
// Depends on lspv_pkg.
//
//  channel   | beat carries                                   | handshake
//  ----------+------------------------------------------------+-----------------------
//  s_axis    | tuser: action; tdata: length, address, samples,| tvalid/tready
//            |   mix pair                                      |
//  m_axis    | tdata: out_left, out_right, voice_active        | tvalid/tready
//  cfg       | register index and data                         | i_cfg_we, no wait
//
// One beat is taken every cycle while the output register is free or being drained.
// A tick result passes three registered stages after its beat: frame store read, gain multiply,
// mix add with saturation. The frame store has one write and one read port; a load
// writes at acceptance, so a tick in the very next cycle already reads the new frame.
// Reset is synchronous and clears the voice state and registers; the frame store is
// not cleared and needs no clearing pass. A stall on m_axis freezes every stage and
// drops s_axis_tready.
module looping_sample_playback_voice_core #(
    parameter int GAIN_FRAC_BITS = lspv_pkg::C_GAIN_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [lspv_pkg::C_CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lspv_pkg::C_CFG_DATA_W-1:0]   i_cfg_data,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // frame_count, address, sample_left, sample_right, mix_left, mix_right, zero pad
    input  logic [lspv_pkg::C_IN_DATA_W-1:0]    s_axis_tdata,
    // action
    input  logic [1:0]                          s_axis_tuser,
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_left, out_right, voice_active, zero pad
    output logic [lspv_pkg::C_OUT_DATA_W-1:0]   m_axis_tdata
);
    import lspv_pkg::*;

    localparam int SUM_W  = C_MIX_W + 2;
    localparam int PROD_W = C_SAMP_W + C_GAIN_W;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (C_MIX_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(1 << (C_MIX_W - 1));

    // signed zero keeps the gain products signed inside the select
    localparam logic signed [PROD_W-1:0] PROD_ZERO = '0;

    // configuration registers
    logic signed [C_GAIN_W-1:0] r_gain_l, r_gain_r;
    logic                       r_loop_en;
    logic [C_POS_W-1:0]         r_loop_begin, r_loop_finish;

    // voice state
    logic [C_POS_W-1:0] r_pos, n_pos;
    logic [C_POS_W-1:0] r_len, n_len;
    logic               r_playing, n_playing;
    logic [C_POS_W-1:0] r_ls, n_ls;
    logic [C_POS_W-1:0] r_le, n_le;

    logic [2*C_SAMP_W-1:0] mem_frames [C_MAX_FRAMES];

    // pipeline
    logic                       w_adv, w_acc;
    t_action                    w_act;
    logic [C_POS_W-1:0]         w_fc;
    logic [C_ADDR_W-1:0]        w_addr, w_rd_addr;
    logic signed [C_SAMP_W-1:0] w_sl, w_sr;
    logic signed [C_MIX_W-1:0]  w_ml, w_mr;
    logic                       w_tick_play, w_active;

    logic                       r1_valid, r1_play, r1_active;
    logic signed [C_MIX_W-1:0]  r1_ml, r1_mr;
    logic [2*C_SAMP_W-1:0]      r1_frame;

    logic                       r2_valid, r2_active;
    logic signed [C_MIX_W-1:0]  r2_ml, r2_mr;
    logic signed [PROD_W-1:0]   r2_pl, r2_pr;

    logic                       r_out_valid, r_out_active;
    logic signed [C_MIX_W-1:0]  r_out_l, r_out_r;

    logic signed [PROD_W-1:0]   w_sh_l, w_sh_r;
    logic signed [SUM_W-1:0]    w_sum_l, w_sum_r;
    logic signed [C_MIX_W-1:0]  w_sat_l, w_sat_r;

    // every stage moves together whenever the output register can take a beat
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign w_acc         = s_axis_tvalid && w_adv;

    assign w_act  = t_action'(s_axis_tuser);
    assign w_fc   = s_axis_tdata[C_FC_LSB   +: C_POS_W];
    assign w_addr = s_axis_tdata[C_ADDR_LSB +: C_ADDR_W];
    assign w_sl   = s_axis_tdata[C_SL_LSB   +: C_SAMP_W];
    assign w_sr   = s_axis_tdata[C_SR_LSB   +: C_SAMP_W];
    assign w_ml   = s_axis_tdata[C_ML_LSB   +: C_MIX_W];
    assign w_mr   = s_axis_tdata[C_MR_LSB   +: C_MIX_W];

    // configuration writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_l      <= C_GAIN_UNITY;
            r_gain_r      <= C_GAIN_UNITY;
            r_loop_en     <= 1'b0;
            r_loop_begin  <= '0;
            r_loop_finish <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GAIN_LEFT:   r_gain_l      <= i_cfg_data[C_GAIN_W-1:0];
                REG_GAIN_RIGHT:  r_gain_r      <= i_cfg_data[C_GAIN_W-1:0];
                REG_LOOP_ENABLE: r_loop_en     <= i_cfg_data[0];
                REG_LOOP_BEGIN:  r_loop_begin  <= i_cfg_data[C_POS_W-1:0];
                REG_LOOP_FINISH: r_loop_finish <= i_cfg_data[C_POS_W-1:0];
                default: ;
            endcase
        end
    end

    // voice control: trigger, stop, and the per-tick position step
    always_comb begin
        logic [C_POS_W-1:0] len_c, end_c, start_c, pos_c, pos_nx;
        logic               play_c;
        n_pos       = r_pos;
        n_len       = r_len;
        n_playing   = r_playing;
        n_ls        = r_ls;
        n_le        = r_le;
        len_c       = (w_fc > C_MAX_LEN) ? C_MAX_LEN : w_fc;
        end_c       = (r_loop_finish == '0 || r_loop_finish > len_c) ? len_c : r_loop_finish;
        start_c     = r_loop_begin;
        play_c      = r_playing && (r_len != '0);
        pos_c       = r_pos;
        pos_nx      = r_pos;
        w_tick_play = 1'b0;
        w_active    = 1'b0;
        w_rd_addr   = r_pos[C_ADDR_W-1:0];
        if (start_c >= end_c) begin
            start_c = '0;
            end_c   = len_c;
        end
        // wrap or stop when the position already sits past the sample
        if (play_c && pos_c >= r_len) begin
            if (r_loop_en) begin
                pos_c = (r_ls < r_len) ? r_ls : '0;
            end else begin
                play_c = 1'b0;
            end
        end
        w_rd_addr   = pos_c[C_ADDR_W-1:0];
        w_tick_play = play_c;
        if (play_c) begin
            pos_nx = pos_c + C_POS_W'(1);
            if (r_loop_en) begin
                if (pos_nx >= r_le) begin
                    pos_nx = (r_ls < r_le) ? r_ls : '0;
                end
            end else if (pos_nx >= r_len) begin
                play_c = 1'b0;
            end
        end
        w_active = play_c;
        if (w_acc) begin
            unique case (w_act)
                ACT_TRIGGER: begin
                    n_len = len_c;
                    n_pos = '0;
                    if (len_c == '0) begin
                        n_playing = 1'b0;
                    end else begin
                        n_ls      = start_c;
                        n_le      = end_c;
                        n_playing = 1'b1;
                    end
                end
                ACT_STOP: begin
                    n_playing = 1'b0;
                    n_pos     = '0;
                end
                ACT_LOAD: ;
                ACT_TICK: begin
                    n_pos     = play_c ? pos_nx : r_pos;
                    n_playing = play_c;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_len     <= '0;
            r_playing <= 1'b0;
            r_ls      <= '0;
            r_le      <= '0;
        end else begin
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_playing <= n_playing;
            r_ls      <= n_ls;
            r_le      <= n_le;
        end
    end

    // frame store: right sample in the upper half
    always_ff @(posedge i_clk) begin
        if (w_acc && w_act == ACT_LOAD) begin
            mem_frames[w_addr] <= {w_sr, w_sl};
        end
        if (w_acc && w_act == ACT_TICK) begin
            r1_frame <= mem_frames[w_rd_addr];
        end
    end

    // stage 1: frame read, mix held alongside
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid <= w_acc && w_act == ACT_TICK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_play   <= w_tick_play;
            r1_active <= w_active;
            r1_ml     <= w_ml;
            r1_mr     <= w_mr;
        end
    end

    // stage 2: gain multiply, forced to zero when the voice is silent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_adv) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_active <= r1_active;
            r2_ml     <= r1_ml;
            r2_mr     <= r1_mr;
            r2_pl     <= r1_play ? $signed(r1_frame[C_SAMP_W-1:0]) * r_gain_l : PROD_ZERO;
            r2_pr     <= r1_play ? $signed(r1_frame[2*C_SAMP_W-1:C_SAMP_W]) * r_gain_r
                                 : PROD_ZERO;
        end
    end

    // stage 3: floor shift, mix add, saturate
    assign w_sh_l  = r2_pl >>> GAIN_FRAC_BITS;
    assign w_sh_r  = r2_pr >>> GAIN_FRAC_BITS;
    assign w_sum_l = SUM_W'(r2_ml) + w_sh_l[SUM_W-1:0];
    assign w_sum_r = SUM_W'(r2_mr) + w_sh_r[SUM_W-1:0];

    always_comb begin
        if (w_sum_l > SAT_HI) begin
            w_sat_l = SAT_HI[C_MIX_W-1:0];
        end else if (w_sum_l < SAT_LO) begin
            w_sat_l = SAT_LO[C_MIX_W-1:0];
        end else begin
            w_sat_l = w_sum_l[C_MIX_W-1:0];
        end
        if (w_sum_r > SAT_HI) begin
            w_sat_r = SAT_HI[C_MIX_W-1:0];
        end else if (w_sum_r < SAT_LO) begin
            w_sat_r = SAT_LO[C_MIX_W-1:0];
        end else begin
            w_sat_r = w_sum_r[C_MIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_l      <= w_sat_l;
            r_out_r      <= w_sat_r;
            r_out_active <= r2_active;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(C_OUT_DATA_W - C_OUT_USED)'(0), r_out_active, r_out_r, r_out_l};

endmodule

[rtl/lspv_checker.sv]
// Port-level checks for the looping sample playback voice, with its bind.
// Depends on lspv_pkg and looping_sample_playback_voice_core.
module lspv_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [lspv_pkg::C_OUT_DATA_W-1:0]   m_axis_tdata
);
    import lspv_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed under stall");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat present after reset");

    // a free or draining output register always lets a new beat in
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("input stalled while output stage free");

    // input stalls only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

endmodule

bind looping_sample_playback_voice_core lspv_checker u_lspv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
